@@ hw/rtl/adc_burst_moving_average_macros.svh @@
// ----------------------------------------------------------------------------
// ADC burst moving average: assertion macros
// Shared assertion forms for the burst averaging block.
// ----------------------------------------------------------------------------
`ifndef ADC_BURST_MOVING_AVERAGE_MACROS_SVH
`define ADC_BURST_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ABMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/abma_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC burst moving average package
// Payload types, divider request type and fixed widths of the block.
// ----------------------------------------------------------------------------
package abma_pkg;

   // Fixed field and datapath widths.
   localparam int CHAN_W    = 4;
   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = 18;
   localparam int CNT_W     = 7;
   localparam int DIVISOR_W = 7;
   localparam int QUO_W     = 12;
   localparam int STEP_W    = 4;

   // Result status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // One incoming request.
   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
      logic                read_failed;
   } req_type;

   // One result.
   typedef struct packed {
      logic [CHAN_W-1:0]   result_channel;
      logic [SAMPLE_W-1:0] average;
      logic                status;
   } rsp_type;

   // Start command for the window divider.
   typedef struct packed {
      logic                 start;
      logic [SUM_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

endpackage

@@ hw/rtl/abma_ram.sv @@
// ----------------------------------------------------------------------------
// ABMA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module abma_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/abma_div.sv @@
// ----------------------------------------------------------------------------
// ABMA restoring divider
// Produces a 12-bit quotient, one bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module abma_div
   import abma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SUM_W-1:0]     shifted;
   logic                 fits;

   // Trial subtraction of the divisor aligned to the current quotient bit.
   assign shifted = SUM_W'(dsr_ff) << step_ff;
   assign fits    = (rem_ff >= shifted);

   // Next-state logic: load on start, otherwise resolve one bit per cycle.
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         step_in = STEP_W'(QUO_W - 1);
         quo_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in[step_ff] = fits;
         if (fits) begin
            rem_in = rem_ff - shifted;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/adc_burst_moving_average.sv @@
// ----------------------------------------------------------------------------
// ADC burst moving average
// Burst mean followed by a moving average over a per-channel history window.
// ----------------------------------------------------------------------------
// Usage:
// Requests carry a channel, a 12-bit sample and a read-failure flag over a
// valid/ready channel (req_*). Good samples are summed until BURST_SAMPLES
// have arrived; the completing request yields one result on the rsp_*
// channel with the truncated mean of the burst mean and the nonzero entries
// of that channel's history row. A failed read clears the running burst and
// yields an error result with a zero average. Good samples on a channel
// of CHANNELS or more are dropped without a result.
// Flow: a sample that does not complete a burst leaves the block ready for
// the next request; a failed read first passes through the respond state.
// A completing sample holds the input until its result is in the output
// register: the row is read and written back while the burst sum is scaled
// by a constant reciprocal, the HISTORY_DEPTH entries of the row are walked,
// the 12-bit window divider runs and the output register is loaded.
// History rows live in one RAM word per channel.
// Reset: the burst is cleared and every history row is marked empty through a
// per-channel valid bit, so no clearing pass is needed.
// Stall: the result sits in an output register; while rsp_ready is low the
// block still takes samples that do not complete a burst.
// ----------------------------------------------------------------------------
`include "adc_burst_moving_average_macros.svh"

module adc_burst_moving_average
   import abma_pkg::*;
#(
   parameter int CHANNELS      = 16,
   parameter int HISTORY_DEPTH = 4,
   parameter int BURST_SAMPLES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W  = HISTORY_DEPTH * SAMPLE_W;
   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int USED_W = $clog2(HISTORY_DEPTH + 2);

   // Burst mean by reciprocal multiplication, exact for every burst sum.
   localparam int MEAN_SHIFT = SUM_W + $clog2(BURST_SAMPLES);
   localparam int MUL_W      = SUM_W + 2;
   localparam int PROD_W     = SUM_W + MUL_W;
   localparam logic [MUL_W-1:0] MEAN_MUL =
      MUL_W'(((64'd1 << MEAN_SHIFT) + 64'(BURST_SAMPLES) - 64'd1) / 64'(BURST_SAMPLES));

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MEAN = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_DIVS = 3'd4;
   localparam logic [2:0] ST_AVG  = 3'd5;
   localparam logic [2:0] ST_RESP = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [CHANNELS-1:0] row_valid_ff, row_valid_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SUM_W-1:0]    total_ff, total_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [SAMPLE_W-1:0] res_avg_ff, res_avg_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic [SUM_W-1:0]    sum_next;
   logic [CNT_W-1:0]    count_next;
   logic                chan_ok;
   logic [ADDR_W-1:0]   row_addr;
   logic [SAMPLE_W-1:0] oldest;
   logic [PROD_W-1:0]   mean_product;
   logic [SAMPLE_W-1:0] burst_mean;

   div_req_type         div_req;
   logic                div_done;
   logic [QUO_W-1:0]    div_quo;

   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_W-1:0]    ram_rd_data;

   // Input handshake and burst arithmetic.
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign sum_next   = sum_ff + SUM_W'(req_data.sample);
   assign count_next = count_ff + 1'b1;
   assign chan_ok    = ({1'b0, req_data.channel} < (CHAN_W + 1)'(CHANNELS));
   assign row_addr   = chan_ff[ADDR_W-1:0];
   assign oldest     = row_ff[SAMPLE_W-1:0];

   // The completed burst sum waits in total_ff while the row is read.
   assign mean_product = PROD_W'(total_ff) * PROD_W'(MEAN_MUL);
   assign burst_mean   = mean_product[MEAN_SHIFT +: SAMPLE_W];

   // History rows, one RAM word per channel, oldest entry in the low bits.
   assign ram_rd_en   = accept;
   assign ram_wr_en   = (state_ff == ST_MEAN);
   assign ram_wr_data = {mean_ff, row_ff[ROW_W-1:SAMPLE_W]};

   abma_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_data.channel[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Divider for the window mean; the divisor is the number of entries used.
   always_comb begin
      div_req = '0;
      if (state_ff == ST_DIVS) begin
         div_req.start    = 1'b1;
         div_req.dividend = total_ff;
         div_req.divisor  = DIVISOR_W'(used_ff);
      end
   end

   abma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sequencer: accept, read row and scale the burst sum, store, walk the
   // row, divide, respond; a failed read goes from accept straight to respond.
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      chan_in       = chan_ff;
      row_valid_in  = row_valid_ff;
      row_in        = row_ff;
      total_in      = total_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      mean_in       = mean_ff;
      res_avg_in    = res_avg_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_data.read_failed) begin
                  sum_in        = '0;
                  count_in      = '0;
                  chan_in       = req_data.channel;
                  res_avg_in    = '0;
                  res_status_in = STATUS_FAIL;
                  state_in      = ST_RESP;
               end else if (!chan_ok) begin
                  state_in = ST_IDLE;
               end else if (count_next >= CNT_W'(BURST_SAMPLES)) begin
                  sum_in   = '0;
                  count_in = '0;
                  chan_in  = req_data.channel;
                  total_in = sum_next;
                  state_in = ST_LOAD;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
         ST_LOAD: begin
            row_in   = row_valid_ff[row_addr] ? ram_rd_data : '0;
            mean_in  = burst_mean;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            row_valid_in[row_addr] = 1'b1;
            total_in = SUM_W'(mean_ff);
            used_in  = USED_W'(1);
            idx_in   = '0;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (oldest != '0) begin
               total_in = total_ff + SUM_W'(oldest);
               used_in  = used_ff + 1'b1;
            end
            row_in = row_ff >> SAMPLE_W;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (div_done) begin
               res_avg_in    = div_quo;
               res_status_in = STATUS_OK;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_channel = chan_ff;
               rsp_data_in.average        = res_avg_ff;
               rsp_data_in.status         = res_status_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers: control state is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chan_ff       <= chan_in;
      row_ff        <= row_in;
      total_ff      <= total_in;
      used_ff       <= used_in;
      idx_ff        <= idx_in;
      mean_ff       <= mean_in;
      res_avg_ff    <= res_avg_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The running burst never holds a full burst between requests.
   `ABMA_ASSERT_NOW(a_burst_short, clock, reset, 1'b1, count_ff < CNT_W'(BURST_SAMPLES), "burst count reached burst length")
   // The divider only finishes while the sequencer waits for it.
   `ABMA_ASSERT_NOW(a_div_expected, clock, reset, div_done, (state_ff == ST_AVG), "unexpected divider completion")
   // An error result never carries an average.
   `ABMA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status == STATUS_FAIL), rsp_data_ff.average == '0, "error result with nonzero average")
   // A completed history write marks its row as filled.
   `ABMA_ASSERT_NEXT(a_row_marked, clock, reset, ram_wr_en, row_valid_ff[row_addr], "written history row not marked valid")

endmodule

@@ tb/sv/adc_burst_moving_average_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADC burst moving average testbench
// Sends bursts of ADC samples, including aborted, mixed-channel and
// zero-mean bursts, with random gaps and result stalls. It checks every
// result against its own model of the burst and history-window arithmetic.
// ----------------------------------------------------------------------------
module adc_burst_moving_average_tb;
   import abma_pkg::*;

   localparam int CHANNELS      = 16;
   localparam int HISTORY_DEPTH = 4;
   localparam int BURST_SAMPLES = 8;
   localparam int ITEM_TARGET   = 750;
   localparam int CALM_TAIL     = 100;
   localparam int DRAIN_CYCLES  = 64;
   localparam int STALL_LIMIT   = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Requests waiting to be driven and results still owed by the block.
   req_type pending_requests[$];
   rsp_type expected_results[$];

   // Model state: running burst and per-channel history window.
   logic [SUM_W-1:0]    burst_total;
   logic [CNT_W-1:0]    burst_seen;
   logic [SAMPLE_W-1:0] window_mem[CHANNELS][HISTORY_DEPTH];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned gap_odds       = 0;
   int unsigned stall_odds     = 0;
   int unsigned pace_timer     = 0;
   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;

   adc_burst_moving_average #(
      .CHANNELS      (CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .BURST_SAMPLES (BURST_SAMPLES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // One line per mismatch, and a running count.
   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("ERROR at %0t: %s is %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // Averages a new burst mean with the nonzero history entries of its row,
   // then shifts the row and stores the new mean as the newest entry.
   function automatic logic [SAMPLE_W-1:0] smooth_into_window(
         input int unsigned row, input logic [SAMPLE_W-1:0] mean_value);
      int unsigned total;
      int unsigned used;
      total = mean_value;
      used  = 1;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (window_mem[row][i] != '0) begin
            total += window_mem[row][i];
            used++;
         end
      end
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         window_mem[row][i] = window_mem[row][i + 1];
      end
      window_mem[row][HISTORY_DEPTH - 1] = mean_value;
      return SAMPLE_W'(total / used);
   endfunction

   // Applies one accepted request to the model and queues any result.
   task automatic predict_sample(input req_type req);
      rsp_type             rsp;
      logic [SAMPLE_W-1:0] mean_value;
      if (req.read_failed) begin
         burst_total = '0;
         burst_seen  = '0;
         rsp.result_channel = req.channel;
         rsp.average        = '0;
         rsp.status         = STATUS_FAIL;
         expected_results.push_back(rsp);
      end else if (req.channel < CHANNELS) begin
         burst_total = burst_total + SUM_W'(req.sample);
         burst_seen  = burst_seen + 1'b1;
         if (burst_seen >= BURST_SAMPLES) begin
            mean_value  = SAMPLE_W'(burst_total / BURST_SAMPLES);
            burst_total = '0;
            burst_seen  = '0;
            rsp.result_channel = req.channel;
            rsp.average        = smooth_into_window(req.channel, mean_value);
            rsp.status         = STATUS_OK;
            expected_results.push_back(rsp);
         end
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned style);
      case (style)
         0: return SAMPLE_W'($urandom_range(0, 7));
         1: return SAMPLE_W'($urandom_range(4088, 4095));
         2: return SAMPLE_W'($urandom_range(1900, 2200));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_request(input int unsigned ch, input logic [SAMPLE_W-1:0] smp,
                                input logic failed);
      req_type req;
      req.channel     = CHAN_W'(ch);
      req.sample      = smp;
      req.read_failed = failed;
      pending_requests.push_back(req);
   endtask

   // Chooses new gap and stall rates now and then, none near the end.
   always @(posedge clock) begin
      pace_timer <= pace_timer + 1;
      if (pending_requests.size() < CALM_TAIL) begin
         gap_odds   <= 0;
         stall_odds <= 0;
      end else if (pace_timer % 97 == 0) begin
         gap_odds   <= $urandom_range(0, 2) * 2;
         stall_odds <= $urandom_range(0, 2) * 2;
      end
   end

   // Request driver: takes the next pending request once the previous one
   // has been accepted, with random gaps in between.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_requests.size() != 0) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 7) < gap_odds) begin
               gap_left = $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 7) < stall_odds) begin
            stall_left = $urandom_range(1, 6);
         end
      end
   end

   // Monitor: checks results, predicts accepted requests, and watches for
   // a block that has stopped moving.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, channel", rsp_data.result_channel, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_channel !== want.result_channel)
                  report_mismatch("result_channel", rsp_data.result_channel,
                                  want.result_channel);
               if (rsp_data.average !== want.average)
                  report_mismatch("average", rsp_data.average, want.average);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            predict_sample(req_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("adc_burst_moving_average test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned kind;
      int unsigned ch;
      int unsigned style;
      int unsigned abort_at;
      bit          mixed;

      burst_total = '0;
      burst_seen  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            window_mem[c][i] = '0;
         end
      end

      // Full-scale burst on the top channel.
      for (int k = 0; k < BURST_SAMPLES; k++) queue_request(15, 12'hFFF, 1'b0);
      // Failed read with every other field at its maximum.
      queue_request(15, 12'hFFF, 1'b1);
      // A partial burst cut short by a failed read.
      for (int k = 0; k < 3; k++) queue_request(7, 12'h800, 1'b0);
      queue_request(0, 12'h000, 1'b1);
      // Mixed channels with a zero mean, credited to the channel that ends it.
      for (int k = 0; k < BURST_SAMPLES; k++) begin
         queue_request((k == BURST_SAMPLES - 1) ? 0 : k + 1, (k == 0) ? 12'h000 : 12'h001,
                       1'b0);
      end

      // Mostly whole bursts on a few channels so the windows fill and shift;
      // some are aborted or mixed, plus single stray requests.
      while (pending_requests.size() < ITEM_TARGET) begin
         kind  = $urandom_range(0, 99);
         ch    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CHANNELS - 1)
                                             : $urandom_range(0, 2);
         style = $urandom_range(0, 5);
         if (kind < 8) begin
            queue_request($urandom_range(0, CHANNELS - 1), SAMPLE_W'($urandom),
                          1'($urandom_range(0, 1)));
         end else begin
            abort_at = (kind < 22) ? $urandom_range(0, BURST_SAMPLES - 1) : BURST_SAMPLES;
            mixed    = (kind >= 22 && kind < 32);
            for (int k = 0; k < BURST_SAMPLES; k++) begin
               if (k == abort_at) begin
                  queue_request($urandom_range(0, CHANNELS - 1), SAMPLE_W'($urandom), 1'b1);
                  break;
               end
               queue_request((mixed && k < BURST_SAMPLES - 1) ?
                             $urandom_range(0, CHANNELS - 1) : ch,
                             pick_sample(style), 1'b0);
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("adc_burst_moving_average test passed");
      end else begin
         $display("adc_burst_moving_average test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/abma_pkg.sv
hw/rtl/abma_ram.sv
hw/rtl/abma_div.sv
hw/rtl/adc_burst_moving_average.sv
tb/sv/adc_burst_moving_average_tb.sv
